// ===== hw/rtl/jac_pkg.sv =====
package jac_pkg;

	localparam int MAX_GRID = 32;
	localparam int CW = $clog2(MAX_GRID);
	localparam int PLANE_WORDS = MAX_GRID * MAX_GRID;
	localparam int SRC_AW = 2 * CW;
	localparam int PLANE_AW = 2 * CW + 1;
	localparam int GS_W = 6;
	localparam int H_W = 25;
	localparam int TOL_W = 63;
	localparam int DIV_W = 33;

	localparam logic [TOL_W-1:0] SAT63 = {TOL_W{1'b1}};
	localparam logic [GS_W-1:0] GS_RESET = 6'd15;
	localparam logic [H_W-1:0] H_RESET = 25'd85598;
	localparam logic [TOL_W-1:0] TOL_RESET = 63'd281474977;
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	typedef enum logic [1:0] {
		CFG_GRID_SIZE = 2'd0,
		CFG_H_SQUARED = 2'd1,
		CFG_TOLERANCE = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		RD_CTR   = 3'd0,
		RD_WEST  = 3'd1,
		RD_EAST  = 3'd2,
		RD_NORTH = 3'd3,
		RD_SOUTH = 3'd4,
		RD_BELOW = 3'd5
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_READ_END,
		S_MUL,
		S_NUM,
		S_DSTART,
		S_DIV,
		S_DIFF,
		S_SQ,
		S_ACC,
		S_OUT1,
		S_OUT2,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic    latch;
		rd_sel_t rd_sel;
		logic    cap_en;
		rd_sel_t cap_sel;
		logic    mul;
		logic    num;
		logic    div_start;
		logic    diff;
		logic    sq;
		logic    acc;
		logic    out_second;
		logic    write;
	} cmd_t;

	typedef struct packed {
		logic k_zero;
		logic last_plane;
		logic edge_pt;
		logic div_done;
	} st_t;

endpackage

// ===== hw/rtl/jac_ram.sv =====
module jac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/jac_div3.sv =====
module jac_div3 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [jac_pkg::DIV_W-1:0] dividend,
	output logic [jac_pkg::DIV_W-1:0] quot,
	output logic                      done
);
	import jac_pkg::*;

	logic [DIV_W+31:0] prod_q;
	logic              busy_q;

	// Division by three as a multiply by the rounded-up reciprocal of 3 in Q0.33.
	// The quotient is exact for every dividend below 2^33.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= {32'd0, dividend} * {33'd0, RECIP3};
		end
	end

	assign quot = DIV_W'(prod_q[DIV_W+31:DIV_W]);
	assign done = !busy_q;

endmodule

// ===== hw/rtl/jac_dp.sv =====
module jac_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  jac_pkg::cmd_t            cmd,
	output jac_pkg::st_t             st,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [62:0]              cfg_wdata,
	input  logic signed [31:0]       old_value,
	input  logic signed [31:0]       source_value,
	output logic signed [31:0]       new_value,
	output logic [62:0]              sweep_sq_diff,
	output logic                     converged,
	output logic                     last
);
	import jac_pkg::*;

	logic [GS_W-1:0]  gs_q;
	logic [H_W-1:0]   h_q;
	logic [TOL_W-1:0] tol_q;
	logic [CW-1:0]    col_q, row_q, pl_q;
	logic [TOL_W-1:0] acc_q;

	logic [31:0]        old_q, srcin_q;
	logic signed [31:0] ov_q, src_q;
	logic signed [34:0] sum_q;
	logic signed [57:0] prod_q;
	logic [38:0]        t_q;
	logic               neg_q, sat_q;
	logic [31:0]        nv_q;
	logic [31:0]        m_q;
	logic [63:0]        sq_q;

	logic [GS_W-1:0] n6;
	logic [CW-1:0]   nm1;
	logic            last_pt, grid_wr;

	logic [PLANE_AW-1:0] p_raddr, p_waddr;
	logic [SRC_AW-1:0]   s_addr;
	logic [31:0]         p_rdata, s_rdata;
	logic [CW-1:0]       ri, rj;
	logic                rbank;

	logic signed [63:0] sumx, prodx, num;
	logic [63:0]        mag, rnd;
	logic [31:0]        q, nvc;
	logic signed [32:0] d;
	logic [DIV_W-1:0]   quot;
	logic               div_done;
	logic [TOL_W-1:0]   sqs;
	logic [63:0]        acc_sum;

	// Grid size in use, clamped to the supported range.
	always_comb begin
		if (gs_q < GS_W'(3)) begin
			n6 = GS_W'(3);
		end else if (gs_q > GS_W'(MAX_GRID)) begin
			n6 = GS_W'(MAX_GRID);
		end else begin
			n6 = gs_q;
		end
	end
	assign nm1 = CW'(n6 - 1'b1);

	assign last_pt = (pl_q >= nm1) && (col_q >= nm1) && (row_q >= nm1);
	assign grid_wr = cfg_we && (cfg_index == CFG_GRID_SIZE);

	assign st.k_zero = (pl_q == '0);
	assign st.last_plane = (pl_q >= nm1);
	assign st.edge_pt = (col_q == '0) || (col_q == nm1) || (row_q == '0) || (row_q == nm1)
		|| (pl_q == CW'(1));
	assign st.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= GS_RESET;
			h_q <= H_RESET;
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_SIZE: gs_q <= cfg_wdata[GS_W-1:0];
				CFG_H_SQUARED: h_q <= cfg_wdata[H_W-1:0];
				CFG_TOLERANCE: tol_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pl_q <= '0;
			acc_q <= '0;
		end else if (grid_wr) begin
			col_q <= '0;
			row_q <= '0;
			pl_q <= '0;
			acc_q <= '0;
		end else if (cmd.write) begin
			if (last_pt) begin
				col_q <= '0;
				row_q <= '0;
				pl_q <= '0;
				acc_q <= '0;
			end else if (col_q >= nm1) begin
				col_q <= '0;
				if (row_q >= nm1) begin
					row_q <= '0;
					pl_q <= (pl_q >= nm1) ? '0 : pl_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (cmd.acc) begin
			acc_q <= acc_sum[63] ? SAT63 : acc_sum[TOL_W-1:0];
		end
	end

	// Neighbour addresses; the previous plane sits in the bank opposite the current one.
	always_comb begin
		ri = col_q;
		rj = row_q;
		rbank = ~pl_q[0];
		case (cmd.rd_sel)
			RD_CTR: ;
			RD_WEST: ri = col_q - 1'b1;
			RD_EAST: ri = col_q + 1'b1;
			RD_NORTH: rj = row_q - 1'b1;
			RD_SOUTH: rj = row_q + 1'b1;
			RD_BELOW: rbank = pl_q[0];
			default: ;
		endcase
	end
	assign p_raddr = {rbank, rj, ri};
	assign p_waddr = {pl_q[0], row_q, col_q};
	assign s_addr = {row_q, col_q};

	jac_ram #(.WIDTH(32), .DEPTH(2 * PLANE_WORDS)) u_plane (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (p_waddr),
		.wdata (old_q),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	jac_ram #(.WIDTH(32), .DEPTH(PLANE_WORDS)) u_src (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (s_addr),
		.wdata (srcin_q),
		.raddr (s_addr),
		.rdata (s_rdata)
	);

	// Numerator in Q.48 and rounding before the divide by six.
	assign sumx = {{29{sum_q[34]}}, sum_q};
	assign prodx = {{6{prod_q[57]}}, prod_q};
	assign num = (sumx <<< 24) - prodx;
	assign mag = num[63] ? 64'(-num) : 64'(num);
	assign rnd = mag + 64'd50331648;

	jac_div3 u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (t_q[DIV_W-1:0]),
		.quot     (quot),
		.done     (div_done)
	);

	assign q = quot[31:0];

	always_comb begin
		if (st.edge_pt) begin
			nvc = ov_q;
		end else if (sat_q) begin
			nvc = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			nvc = neg_q ? 32'(-q) : q;
		end
	end
	assign d = $signed({nvc[31], nvc}) - $signed({ov_q[31], ov_q});

	assign sqs = sq_q[63] ? SAT63 : sq_q[TOL_W-1:0];
	assign acc_sum = {1'b0, acc_q} + {1'b0, sqs};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			old_q <= old_value;
			srcin_q <= source_value;
			sum_q <= 35'(old_value);
		end
		if (cmd.cap_en) begin
			if (cmd.cap_sel == RD_CTR) begin
				ov_q <= p_rdata;
				src_q <= s_rdata;
			end else begin
				sum_q <= sum_q + 35'($signed(p_rdata));
			end
		end
		if (cmd.mul) begin
			prod_q <= src_q * $signed({1'b0, h_q});
		end
		if (cmd.num) begin
			t_q <= rnd[63:25];
			neg_q <= num[63];
			sat_q <= (rnd[63:25] >= 39'h1_8000_0000);
		end
		if (cmd.diff) begin
			nv_q <= nvc;
			m_q <= d[32] ? 32'(-d) : 32'(d);
		end
		if (cmd.sq) begin
			sq_q <= m_q * m_q;
		end
	end

	assign new_value = cmd.out_second ? old_q : nv_q;
	assign last = cmd.out_second && last_pt;
	assign sweep_sq_diff = last ? acc_q : '0;
	assign converged = last && (acc_q <= tol_q);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write && last_pt && !grid_wr) |=> (acc_q == '0) && (pl_q == '0))
		else $error("sweep did not restart after its last word");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> (acc_q >= $past(acc_q)))
		else $error("accumulator decreased");

endmodule

// ===== hw/rtl/jac_ctrl.sv =====
module jac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  jac_pkg::st_t   st,
	output jac_pkg::cmd_t  cmd
);
	import jac_pkg::*;

	state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.rd_sel = rd_sel_t'(cnt_q);
		cmd.cap_sel = rd_sel_t'(cnt_q - 3'd1);
		unique case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = st.k_zero ? S_WRITE : S_READ;
				end
			end
			S_READ: begin
				cmd.cap_en = (cnt_q != '0);
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'(RD_BELOW)) begin
					state_d = S_READ_END;
				end
			end
			S_READ_END: begin
				cmd.cap_en = 1'b1;
				state_d = st.edge_pt ? S_DIFF : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.num = 1'b1;
				state_d = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_OUT1;
			end
			S_OUT1: begin
				if (!out_stall) begin
					state_d = st.last_plane ? S_OUT2 : S_WRITE;
				end
			end
			S_OUT2: begin
				cmd.out_second = 1'b1;
				if (!out_stall) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT1) || (state_q == S_OUT2);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT2) |-> st.last_plane)
		else $error("second result outside the last plane");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_READ) || (state_q == S_WRITE))
		else $error("accepted word not processed");

endmodule

// ===== hw/rtl/jacobi_7point_poisson_sweep.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   old_value, source_value
// out       output     out_valid / out_stall new_value, sweep_sq_diff, converged, last
// cfg       input      cfg_we                cfg_index, cfg_wdata
//
// One word is processed at a time. A point in plane 0 is only written back. A boundary
// point runs the plane read sequence (6 reads), the difference, square and accumulate,
// its output (two in the last plane, each held by out_stall) and the write-back; an
// interior point adds the multiply, round and reciprocal divide by three after the reads.
// arst_n clears the counters and accumulator and resets the config registers to defaults;
// the plane memories are not cleared. in_stall stays high from acceptance until the
// word's results are taken and its values are written back.
module jacobi_7point_poisson_sweep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] old_value,
	input  logic signed [31:0] source_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_value,
	output logic [62:0]        sweep_sq_diff,
	output logic               converged,
	output logic               last,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [62:0]        cfg_wdata
);
	import jac_pkg::*;

	cmd_t cmd;
	st_t  st;

	jac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	jac_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.old_value     (old_value),
		.source_value  (source_value),
		.new_value     (new_value),
		.sweep_sq_diff (sweep_sq_diff),
		.converged     (converged),
		.last          (last)
	);

endmodule
